// File: src/gtpc_pkg.sv
package gtpc_pkg;

  localparam int unsigned POS_W = 17;
  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam logic [7:0] EXP_TYPE_RESET = 8'h10;

  localparam logic [7:0] IE_IMSI = 8'h02;
  localparam logic [7:0] IE_PDP  = 8'h80;
  localparam logic [7:0] IE_APN  = 8'h83;
  localparam logic [7:0] IE_GGSN = 8'h85;

  localparam logic [1:0] KIND_APN_FIRST = 2'd0;
  localparam logic [1:0] KIND_APN_MORE  = 2'd1;
  localparam logic [1:0] KIND_SUMMARY   = 2'd2;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_SHORT     = 4'd1;
  localparam logic [3:0] ST_VERSION   = 4'd2;
  localparam logic [3:0] ST_PROTO     = 4'd3;
  localparam logic [3:0] ST_SHORT_OPT = 4'd4;
  localparam logic [3:0] ST_LEN_EXC   = 4'd5;
  localparam logic [3:0] ST_LEN_SMALL = 4'd6;
  localparam logic [3:0] ST_TYPE      = 4'd7;
  localparam logic [3:0] ST_IMSI      = 4'd8;
  localparam logic [3:0] ST_TLV_HDR   = 4'd9;
  localparam logic [3:0] ST_TLV_PAY   = 4'd10;
  localparam logic [3:0] ST_APN_LABEL = 4'd11;
  localparam logic [3:0] ST_NO_IES    = 4'd12;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  apn_char;
    logic [3:0]  status;
    logic [7:0]  msg_type;
    logic [7:0]  flags;
    logic [31:0] teid;
    logic [15:0] seq;
    logic [63:0] imsi;
    logic [4:0]  imsi_cnt;
    logic [7:0]  pdp;
    logic [31:0] ggsn;
    logic [3:0]  mask;
  } res_t;

  typedef struct packed {
    logic char_vld;
    logic sum_vld;
    res_t char_res;
    res_t sum_res;
  } core_out_t;

endpackage

// File: src/gtpv1c_request_parser.sv
// GTPv1-C request parser.
// Input channel: one packet byte per beat (packet_byte_i, end_of_packet_i on
// the final byte), valid/ready handshake. Output channel: result beats,
// valid/ready. result_kind 0/1 carries an APN character (dot for label
// separators and non-printable bytes), kind 2 the end-of-packet summary.
// Each accepted byte is parsed in the cycle it arrives; its results are
// registered into a four-entry output queue whose head drives the outputs.
// A byte yields at most two beats (an APN character or dot plus the
// summary on the final byte).
// Throughput: one byte per cycle while the queue has two free entries;
// in_ready_o drops when the receiver stalls and the queue fills, so the
// sender is held, never dropped.
// Reset clears the parser to the header phase, empties the queue and sets
// expected_message_type to 0x10. The user must write the register (APB,
// address 0) only while no packet is in flight; the block does not enforce it.
module gtpv1c_request_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  packet_byte_i,
  input  logic        end_of_packet_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  apn_char_o,
  output logic [3:0]  status_o,
  output logic [7:0]  message_type_o,
  output logic [7:0]  header_flags_o,
  output logic [31:0] tunnel_id_o,
  output logic [15:0] sequence_number_o,
  output logic [63:0] imsi_digits_o,
  output logic [4:0]  imsi_digit_count_o,
  output logic [7:0]  pdp_type_number_o,
  output logic [31:0] ggsn_ipv4_o,
  output logic [3:0]  present_mask_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gtpc_pkg::*;

  logic [7:0] exp_type_q;
  logic       in_fire;
  core_out_t  core_out;

  // output queue
  res_t       fifo_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  logic [1:0] npush;
  logic       pop;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {24'h0, exp_type_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_type_q <= EXP_TYPE_RESET;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      exp_type_q <= pwdata[7:0];
    end
  end

  assign in_ready_o = (cnt_q <= 3'd2);
  assign in_fire    = in_valid_i && in_ready_o;

  gtpc_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (in_fire),
    .byte_i     (packet_byte_i),
    .last_i     (end_of_packet_i),
    .exp_type_i (exp_type_q),
    .out_o      (core_out)
  );

  assign npush = {1'b0, core_out.char_vld} + {1'b0, core_out.sum_vld};
  assign pop   = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (core_out.char_vld) fifo_q[wp_q] <= core_out.char_res;
    if (core_out.sum_vld) fifo_q[wp_q + 2'(core_out.char_vld)] <= core_out.sum_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + npush;
      rp_q  <= rp_q + 2'(pop);
      cnt_q <= cnt_q + 3'(npush) - 3'(pop);
    end
  end

  assign out_valid_o        = (cnt_q != '0);
  assign result_kind_o      = fifo_q[rp_q].kind;
  assign apn_char_o         = fifo_q[rp_q].apn_char;
  assign status_o           = fifo_q[rp_q].status;
  assign message_type_o     = fifo_q[rp_q].msg_type;
  assign header_flags_o     = fifo_q[rp_q].flags;
  assign tunnel_id_o        = fifo_q[rp_q].teid;
  assign sequence_number_o  = fifo_q[rp_q].seq;
  assign imsi_digits_o      = fifo_q[rp_q].imsi;
  assign imsi_digit_count_o = fifo_q[rp_q].imsi_cnt;
  assign pdp_type_number_o  = fifo_q[rp_q].pdp;
  assign ggsn_ipv4_o        = fifo_q[rp_q].ggsn;
  assign present_mask_o     = fifo_q[rp_q].mask;

endmodule

// File: src/gtpc_core.sv
module gtpc_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  input  logic [7:0]        exp_type_i,
  output gtpc_pkg::core_out_t out_o
);
  import gtpc_pkg::*;

  typedef enum logic [3:0] {
    PH_HDR, PH_OPT, PH_TYPE, PH_IMSI, PH_LEN1, PH_LEN2,
    PH_VALUE, PH_APNLEN, PH_APNDATA, PH_APNSKIP, PH_DONE
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [63:0]      hdr_q, hdr_d;
  logic [7:0]       etype_q, etype_d;
  logic [15:0]      rem_q, rem_d;
  logic [7:0]       label_q, label_d;
  logic [63:0]      imsi_q, imsi_d;
  logic [4:0]       icnt_q, icnt_d;
  logic [7:0]       pdp_q, pdp_d;
  logic [31:0]      ggsn_q, ggsn_d;
  logic [3:0]       pres_q, pres_d;
  logic [3:0]       err_q, err_d;
  logic [15:0]      seq_q, seq_d;
  logic             take_q, take_d;

  always_comb begin
    logic [POS_W-1:0] total, tot2;
    logic [POS_W:0]   pos_x, tot_x;
    logic [7:0]       f, fl;
    logic [15:0]      r;
    logic [7:0]       lab;
    logic [3:0]       nib;
    logic             opt;
    logic [3:0]       st;
    phase_d = phase_q; pos_d = pos_q; hdr_d = hdr_q; etype_d = etype_q;
    rem_d = rem_q; label_d = label_q; imsi_d = imsi_q; icnt_d = icnt_q;
    pdp_d = pdp_q; ggsn_d = ggsn_q; pres_d = pres_q; err_d = err_q;
    seq_d = seq_q; take_d = take_q;
    out_o = '0;
    total = POS_W'(8) + POS_W'(hdr_q[47:32]);
    pos_x = {1'b0, pos_q};
    tot_x = {1'b0, total};
    f = '0; r = '0; lab = '0; nib = '0; fl = '0; opt = 1'b0; tot2 = '0; st = ST_OK;
    if (fire_i) begin
      unique case (phase_q)
        PH_HDR: begin
          hdr_d = {hdr_q[55:0], byte_i};
          if (pos_q == POS_W'(7)) begin
            f = hdr_d[63:56];
            if (f[7:5] != 3'd1 || !f[4] || hdr_d[55:48] != exp_type_i) phase_d = PH_DONE;
            else phase_d = (|f[2:0]) ? PH_OPT : PH_TYPE;
          end
        end
        PH_OPT: begin
          if (pos_q == POS_W'(8)) seq_d = {byte_i, 8'h00};
          else if (pos_q == POS_W'(9)) seq_d = {seq_q[15:8], byte_i};
          else if (pos_q == POS_W'(11)) phase_d = (total < POS_W'(12)) ? PH_DONE : PH_TYPE;
        end
        PH_TYPE: begin
          if (pos_q >= total) phase_d = PH_DONE;
          else if (byte_i == IE_IMSI) begin
            if (pos_x + (POS_W+1)'(9) > tot_x) begin
              if (err_q == ST_OK) err_d = ST_IMSI;
              phase_d = PH_DONE;
            end else begin
              imsi_d = '0; icnt_d = '0; pres_d[0] = 1'b0;
              rem_d = 16'd8; phase_d = PH_IMSI;
            end
          end else begin
            if (pos_x + (POS_W+1)'(3) > tot_x) begin
              if (err_q == ST_OK) err_d = ST_TLV_HDR;
              phase_d = PH_DONE;
            end else begin
              etype_d = byte_i; phase_d = PH_LEN1;
            end
          end
        end
        PH_IMSI: begin
          for (int k = 0; k < 2; k++) begin
            nib = (k == 0) ? byte_i[3:0] : byte_i[7:4];
            if (nib <= 4'd9 && icnt_d < 5'd16) begin
              imsi_d = imsi_d | (64'(nib) << {icnt_d[3:0], 2'b00});
              icnt_d = icnt_d + 5'd1;
              pres_d[0] = 1'b1;
            end
          end
          rem_d = rem_q - 16'd1;
          if (rem_d == '0) phase_d = PH_TYPE;
        end
        PH_LEN1: begin
          rem_d = {byte_i, 8'h00}; phase_d = PH_LEN2;
        end
        PH_LEN2: begin
          r = rem_q | {8'h00, byte_i};
          rem_d = r;
          if (pos_x + (POS_W+1)'(1) + (POS_W+1)'(r) > tot_x) begin
            if (err_q == ST_OK) err_d = ST_TLV_PAY;
            phase_d = PH_DONE;
          end else begin
            label_d = '0;
            if (etype_q == IE_APN) pres_d[1] = 1'b0;
            if (etype_q == IE_GGSN) take_d = (r == 16'd4) && !pres_q[2];
            if (r == '0) phase_d = PH_TYPE;
            else phase_d = (etype_q == IE_APN) ? PH_APNLEN : PH_VALUE;
          end
        end
        PH_VALUE: begin
          if (etype_q == IE_PDP && label_q == 8'd1) begin
            pdp_d = byte_i; pres_d[3] = 1'b1;
          end
          if (etype_q == IE_GGSN && take_q) begin
            ggsn_d = {ggsn_q[23:0], byte_i};
            if (rem_q == 16'd1) pres_d[2] = 1'b1;
          end
          if (label_q < 8'd2) label_d = label_q + 8'd1;
          rem_d = rem_q - 16'd1;
          if (rem_d == '0) phase_d = PH_TYPE;
        end
        PH_APNLEN: begin
          r = rem_q - 16'd1;
          rem_d = r;
          if (byte_i == 8'd0) phase_d = (r == '0) ? PH_TYPE : PH_APNSKIP;
          else if (16'(byte_i) > r) begin
            if (err_q == ST_OK) err_d = ST_APN_LABEL;
            phase_d = PH_DONE;
          end else begin
            if (pres_q[1]) begin
              out_o.char_vld = 1'b1;
              out_o.char_res.kind = KIND_APN_MORE;
              out_o.char_res.apn_char = 8'h2E;
            end
            label_d = byte_i; phase_d = PH_APNDATA;
          end
        end
        PH_APNDATA: begin
          out_o.char_vld = 1'b1;
          out_o.char_res.kind = pres_q[1] ? KIND_APN_MORE : KIND_APN_FIRST;
          out_o.char_res.apn_char = (byte_i >= 8'h20 && byte_i <= 8'h7E) ? byte_i : 8'h2E;
          pres_d[1] = 1'b1;
          rem_d = rem_q - 16'd1;
          lab = label_q - 8'd1;
          label_d = lab;
          if (lab == '0) phase_d = (rem_d == '0) ? PH_TYPE : PH_APNLEN;
        end
        PH_APNSKIP: begin
          rem_d = rem_q - 16'd1;
          if (rem_d == '0) phase_d = PH_TYPE;
        end
        default: ;
      endcase
      if (pos_q != POS_MAX) pos_d = pos_q + POS_W'(1);

      if (last_i) begin
        fl   = hdr_d[63:56];
        opt  = |fl[2:0];
        tot2 = POS_W'(8) + POS_W'(hdr_d[47:32]);
        if (pos_d < POS_W'(8)) st = ST_SHORT;
        else if (fl[7:5] != 3'd1) st = ST_VERSION;
        else if (!fl[4]) st = ST_PROTO;
        else if (opt && pos_d < POS_W'(12)) st = ST_SHORT_OPT;
        else if (pos_d < tot2) st = ST_LEN_EXC;
        else if (tot2 < (opt ? POS_W'(12) : POS_W'(8))) st = ST_LEN_SMALL;
        else if (hdr_d[55:48] != exp_type_i) st = ST_TYPE;
        else if (err_d != ST_OK) st = err_d;
        else if (pres_d == '0) st = ST_NO_IES;
        else st = ST_OK;
        out_o.sum_vld = 1'b1;
        out_o.sum_res.kind = KIND_SUMMARY;
        out_o.sum_res.status = st;
        if (st != ST_SHORT) begin
          out_o.sum_res.msg_type = hdr_d[55:48];
          out_o.sum_res.flags = fl;
          out_o.sum_res.teid = hdr_d[31:0];
          if (st != ST_VERSION && st != ST_PROTO && st != ST_SHORT_OPT && opt)
            out_o.sum_res.seq = seq_d;
        end
        if (st == ST_OK || st >= ST_IMSI) begin
          out_o.sum_res.imsi = imsi_d;
          out_o.sum_res.imsi_cnt = icnt_d;
          out_o.sum_res.pdp = pdp_d;
          out_o.sum_res.ggsn = ggsn_d;
          out_o.sum_res.mask = pres_d;
        end
        phase_d = PH_HDR; pos_d = '0; hdr_d = '0; etype_d = '0; rem_d = '0;
        label_d = '0; imsi_d = '0; icnt_d = '0; pdp_d = '0; ggsn_d = '0;
        pres_d = '0; err_d = ST_OK; seq_d = '0; take_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR; pos_q <= '0; hdr_q <= '0; etype_q <= '0; rem_q <= '0;
      label_q <= '0; imsi_q <= '0; icnt_q <= '0; pdp_q <= '0; ggsn_q <= '0;
      pres_q <= '0; err_q <= ST_OK; seq_q <= '0; take_q <= 1'b0;
    end else begin
      phase_q <= phase_d; pos_q <= pos_d; hdr_q <= hdr_d; etype_q <= etype_d;
      rem_q <= rem_d; label_q <= label_d; imsi_q <= imsi_d; icnt_q <= icnt_d;
      pdp_q <= pdp_d; ggsn_q <= ggsn_d; pres_q <= pres_d; err_q <= err_d;
      seq_q <= seq_d; take_q <= take_d;
    end
  end

endmodule

// File: src/gtpc_checker.sv
module gtpc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        end_of_packet_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  result_kind_o,
  input logic [3:0]  status_o,
  input logic [7:0]  message_type_o,
  input logic [31:0] tunnel_id_o,
  input logic [3:0]  present_mask_o
);
  import gtpc_pkg::*;

  a_last_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && end_of_packet_i |=> out_valid_o)
    else $error("no summary after last byte");

  a_char_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o != KIND_SUMMARY |-> status_o == ST_OK && present_mask_o == '0)
    else $error("char beat carries summary fields");

  a_short_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == KIND_SUMMARY && status_o == ST_SHORT
      |-> message_type_o == '0 && tunnel_id_o == '0)
    else $error("short packet summary not cleared");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output beat withdrawn");

endmodule

bind gtpv1c_request_parser gtpc_checker u_gtpc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .end_of_packet_i (end_of_packet_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .result_kind_o   (result_kind_o),
  .status_o        (status_o),
  .message_type_o  (message_type_o),
  .tunnel_id_o     (tunnel_id_o),
  .present_mask_o  (present_mask_o)
);

// File: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gtpc_pkg::*;

  // parser walk phases, local to the predictor
  typedef enum logic [3:0] {
    W_HDR, W_OPT, W_TYPE, W_IMSI, W_LEN1, W_LEN2, W_VALUE,
    W_APNLEN, W_APNDATA, W_APNSKIP, W_DONE
  } walk_e;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASE_BYTES    = 460;
  localparam logic [2:0] ADDR_EXP_TYPE = 3'd0;

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_ready_o;
  logic [7:0]  packet_byte_i;
  logic        end_of_packet_i;
  logic        out_valid_o, out_ready_i;
  logic [1:0]  result_kind_o;
  logic [7:0]  apn_char_o;
  logic [3:0]  status_o;
  logic [7:0]  message_type_o, header_flags_o;
  logic [31:0] tunnel_id_o;
  logic [15:0] sequence_number_o;
  logic [63:0] imsi_digits_o;
  logic [4:0]  imsi_digit_count_o;
  logic [7:0]  pdp_type_number_o;
  logic [31:0] ggsn_ipv4_o;
  logic [3:0]  present_mask_o;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  gtpv1c_request_parser dut (.*);

  // ---------------------------------------------------------------------------
  // Parser shadow: its own copy of the per-packet state and the register.
  // ---------------------------------------------------------------------------
  logic [7:0]  exp_type_reg;
  logic [16:0] sh_pos;
  logic [63:0] sh_hdr;
  walk_e       sh_phase;
  logic [7:0]  sh_etype;
  logic [15:0] sh_erem;
  logic [7:0]  sh_lrem;
  logic [63:0] sh_imsi;
  logic [4:0]  sh_icnt;
  logic [7:0]  sh_pdp;
  logic [31:0] sh_ggsn;
  logic [3:0]  sh_flags;
  logic [3:0]  sh_err;
  logic [15:0] sh_seq;
  logic        sh_take;

  res_t apn_and_summary_q[$];   // beats the parser owes us, oldest first
  int   errors;

  function automatic logic [7:0] hb(int i);
    return sh_hdr[63-8*i -: 8];
  endfunction

  function automatic int unsigned decl_total();
    return 8 + {hb(2), hb(3)};
  endfunction

  function automatic logic has_opt();
    logic [7:0] f0;
    f0 = hb(0);
    return f0[2:0] != 3'd0;
  endfunction

  function automatic void clear_packet();
    sh_pos = '0; sh_hdr = '0; sh_phase = W_HDR; sh_etype = '0; sh_erem = '0;
    sh_lrem = '0; sh_imsi = '0; sh_icnt = '0; sh_pdp = '0; sh_ggsn = '0;
    sh_flags = '0; sh_err = ST_OK; sh_seq = '0; sh_take = 1'b0;
  endfunction

  function automatic void ie_fail(logic [3:0] code);
    if (sh_err == ST_OK) sh_err = code;
    sh_phase = W_DONE;
  endfunction

  function automatic void push_char(logic [1:0] kind, logic [7:0] ch);
    res_t r;
    r = '0; r.kind = kind; r.apn_char = ch;
    apn_and_summary_q.insert(apn_and_summary_q.size(), r);
  endfunction

  function automatic void value_byte_done();
    sh_erem--;
    if (sh_erem == 0) sh_phase = W_TYPE;
  endfunction

  // IE walk for one body byte
  function automatic void walk_ie(logic [7:0] b, int unsigned pos);
    int unsigned total;
    logic [3:0] nib;
    logic [7:0] ch;
    total = decl_total();
    case (sh_phase)
      W_TYPE: begin
        if (pos >= total) sh_phase = W_DONE;
        else if (b == IE_IMSI) begin
          if (pos + 9 > total) ie_fail(ST_IMSI);
          else begin
            sh_imsi = '0; sh_icnt = '0; sh_flags[0] = 1'b0;
            sh_erem = 16'd8; sh_phase = W_IMSI;
          end
        end else if (pos + 3 > total) ie_fail(ST_TLV_HDR);
        else begin
          sh_etype = b; sh_phase = W_LEN1;
        end
      end
      W_IMSI: begin
        for (int k = 0; k < 2; k++) begin
          nib = k == 0 ? b[3:0] : b[7:4];
          if (nib <= 4'd9 && sh_icnt < 5'd16) begin
            sh_imsi |= 64'(nib) << (4 * sh_icnt);
            sh_icnt++;
            sh_flags[0] = 1'b1;
          end
        end
        value_byte_done();
      end
      W_LEN1: begin
        sh_erem = {b, 8'h00}; sh_phase = W_LEN2;
      end
      W_LEN2: begin
        sh_erem[7:0] = b;
        if (pos + 1 + sh_erem > total) ie_fail(ST_TLV_PAY);
        else begin
          sh_lrem = '0;
          if (sh_etype == IE_APN) sh_flags[1] = 1'b0;
          if (sh_etype == IE_GGSN) sh_take = (sh_erem == 16'd4) && !sh_flags[2];
          if (sh_erem == 0) sh_phase = W_TYPE;
          else sh_phase = sh_etype == IE_APN ? W_APNLEN : W_VALUE;
        end
      end
      W_VALUE: begin
        if (sh_etype == IE_PDP && sh_lrem == 8'd1) begin
          sh_pdp = b; sh_flags[3] = 1'b1;
        end
        if (sh_etype == IE_GGSN && sh_take) begin
          sh_ggsn = {sh_ggsn[23:0], b};
          if (sh_erem == 16'd1) sh_flags[2] = 1'b1;
        end
        if (sh_lrem < 8'd2) sh_lrem++;
        value_byte_done();
      end
      W_APNLEN: begin
        sh_erem--;
        if (b == 8'd0) sh_phase = sh_erem == 0 ? W_TYPE : W_APNSKIP;
        else if (16'(b) > sh_erem) ie_fail(ST_APN_LABEL);
        else begin
          if (sh_flags[1]) push_char(KIND_APN_MORE, 8'h2E);
          sh_lrem = b; sh_phase = W_APNDATA;
        end
      end
      W_APNDATA: begin
        ch = (b >= 8'h20 && b <= 8'h7E) ? b : 8'h2E;
        push_char(sh_flags[1] ? KIND_APN_MORE : KIND_APN_FIRST, ch);
        sh_flags[1] = 1'b1;
        sh_erem--; sh_lrem--;
        if (sh_lrem == 0) sh_phase = sh_erem == 0 ? W_TYPE : W_APNLEN;
      end
      W_APNSKIP: value_byte_done();
      default: ;
    endcase
  endfunction

  function automatic void push_summary();
    res_t r;
    int unsigned cnt, hlen;
    logic [7:0] f;
    logic [3:0] st;
    cnt = sh_pos; f = hb(0); hlen = has_opt() ? 12 : 8;
    if (cnt < 8) st = ST_SHORT;
    else if (f[7:5] != 3'd1) st = ST_VERSION;
    else if (!f[4]) st = ST_PROTO;
    else if (has_opt() && cnt < 12) st = ST_SHORT_OPT;
    else if (cnt < decl_total()) st = ST_LEN_EXC;
    else if (decl_total() < hlen) st = ST_LEN_SMALL;
    else if (hb(1) != exp_type_reg) st = ST_TYPE;
    else if (sh_err != ST_OK) st = sh_err;
    else if (sh_flags == 0) st = ST_NO_IES;
    else st = ST_OK;
    r = '0; r.kind = KIND_SUMMARY; r.status = st;
    if (st != ST_SHORT) begin
      r.msg_type = hb(1); r.flags = f; r.teid = sh_hdr[31:0];
      if (st != ST_VERSION && st != ST_PROTO && st != ST_SHORT_OPT && has_opt())
        r.seq = sh_seq;
    end
    if (st == ST_OK || st >= ST_IMSI) begin
      r.imsi = sh_imsi; r.imsi_cnt = sh_icnt; r.pdp = sh_pdp;
      r.ggsn = sh_ggsn; r.mask = sh_flags;
    end
    apn_and_summary_q.insert(apn_and_summary_q.size(), r);
  endfunction

  // one accepted byte
  function automatic void parse_byte(logic [7:0] b, logic last);
    int unsigned pos;
    logic [7:0] f;
    pos = sh_pos;
    if (sh_phase == W_HDR) begin
      sh_hdr = {sh_hdr[55:0], b};
      if (pos == 7) begin
        f = hb(0);
        if (f[7:5] != 3'd1 || !f[4] || hb(1) != exp_type_reg) sh_phase = W_DONE;
        else sh_phase = has_opt() ? W_OPT : W_TYPE;
      end
    end else if (sh_phase == W_OPT) begin
      if (pos == 8) sh_seq = {b, 8'h00};
      else if (pos == 9) sh_seq[7:0] = b;
      else if (pos == 11) sh_phase = decl_total() < 12 ? W_DONE : W_TYPE;
    end else walk_ie(b, pos);
    if (sh_pos != POS_MAX) sh_pos++;
    if (last) begin
      push_summary();
      clear_packet();
    end
  endfunction

  function automatic void cmp(string name, logic [63:0] e, logic [63:0] a);
    if (a !== e) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, e, a);
      errors++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, monitors, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  logic       chk_en;       // directed rows: status typed in by hand
  logic [3:0] chk_status;
  int         quiet_cycles;
  int         send_idle_pct, recv_stall_pct;
  bit         hold_req, hold_done;
  int         hold_left;

  always @(posedge clk_i) begin
    res_t e, a;
    if (rst_ni) begin
      quiet_cycles++;
      if (in_valid_i && in_ready_o) begin
        quiet_cycles = 0;
        parse_byte(packet_byte_i, end_of_packet_i);
        if (chk_en) cmp("directed status", chk_status,
                        apn_and_summary_q[apn_and_summary_q.size()-1].status);
      end
      if (out_valid_o && out_ready_i) begin
        quiet_cycles = 0;
        a = '{result_kind_o, apn_char_o, status_o, message_type_o, header_flags_o,
              tunnel_id_o, sequence_number_o, imsi_digits_o, imsi_digit_count_o,
              pdp_type_number_o, ggsn_ipv4_o, present_mask_o};
        if (apn_and_summary_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none actual %0h", $time, a);
          errors++;
        end else begin
          e = apn_and_summary_q.pop_front();
          cmp("result_kind", e.kind, a.kind);
          cmp("apn_char", e.apn_char, a.apn_char);
          cmp("status", e.status, a.status);
          cmp("message_type", e.msg_type, a.msg_type);
          cmp("header_flags", e.flags, a.flags);
          cmp("tunnel_id", e.teid, a.teid);
          cmp("sequence_number", e.seq, a.seq);
          cmp("imsi_digits", e.imsi, a.imsi);
          cmp("imsi_digit_count", e.imsi_cnt, a.imsi_cnt);
          cmp("pdp_type_number", e.pdp, a.pdp);
          cmp("ggsn_ipv4", e.ggsn, a.ggsn);
          cmp("present_mask", e.mask, a.mask);
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("gtpv1c_request_parser: mismatch");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else
        out_ready_i <= $urandom_range(0, 99) >= recv_stall_pct;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  task automatic send_byte(logic [7:0] b, logic last, logic ck, logic [3:0] st);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      chk_en <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    packet_byte_i <= b;
    end_of_packet_i <= last;
    chk_en <= ck;
    chk_status <= st;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    chk_en <= 1'b0;
    do @(posedge clk_i); while (apn_and_summary_q.size() != 0);
    repeat (8) @(posedge clk_i);   // a byte may still be in flight with no beat
  endtask

  task automatic apb_write(logic [7:0] v);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= ADDR_EXP_TYPE; pwdata <= {24'h0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    exp_type_reg = v;
    psel <= 1'b1; pwrite <= 1'b0; penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    cmp("prdata", {24'h0, v}, prdata);
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk_i);
  endtask

  logic [7:0] pkt[$];
  logic [7:0] body[$];

  // random packet: mostly well-formed, some broken, a little noise
  function automatic void build_packet();
    int n_ie, kind, len, nlab, ll, cut;
    logic [7:0] flags, mtype;
    logic [15:0] dlen;
    logic [31:0] teid;
    logic [7:0] lab[$];
    pkt.delete(); body.delete();
    if ($urandom_range(0, 99) < 5) begin
      repeat ($urandom_range(1, 12)) pkt.insert(pkt.size(), 8'($urandom));
      return;
    end
    n_ie = $urandom_range(0, 4);
    repeat (n_ie) begin
      kind = $urandom_range(0, 4);
      case (kind)
        0: begin
          body.insert(body.size(), IE_IMSI);
          repeat (8) body.insert(body.size(), $urandom_range(0, 9) < 8 ?
              {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))} : 8'($urandom));
        end
        1: begin
          len = $urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : 2;
          body.insert(body.size(), IE_PDP); body.insert(body.size(), 8'h00);
          body.insert(body.size(), 8'(len));
          repeat (len) body.insert(body.size(), 8'($urandom));
        end
        2: begin
          lab.delete();
          nlab = $urandom_range(1, 3);
          repeat (nlab) begin
            ll = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 6);
            lab.insert(lab.size(), $urandom_range(0, 9) == 0 ?
                       8'($urandom_range(0, 20)) : 8'(ll));
            repeat (ll) lab.insert(lab.size(), $urandom_range(0, 7) == 0 ? 8'($urandom)
                                   : 8'($urandom_range(8'h61, 8'h7A)));
          end
          body.insert(body.size(), IE_APN); body.insert(body.size(), 8'h00);
          body.insert(body.size(), 8'(lab.size()));
          foreach (lab[i]) body.insert(body.size(), lab[i]);
        end
        3: begin
          len = $urandom_range(0, 3) == 0 ? $urandom_range(0, 6) : 4;
          body.insert(body.size(), IE_GGSN); body.insert(body.size(), 8'h00);
          body.insert(body.size(), 8'(len));
          repeat (len) body.insert(body.size(), 8'($urandom));
        end
        default: begin
          len = $urandom_range(0, 3);
          body.insert(body.size(), 8'($urandom)); body.insert(body.size(), 8'h00);
          body.insert(body.size(), 8'(len));
          repeat (len) body.insert(body.size(), 8'($urandom));
        end
      endcase
    end
    flags = 8'h30 | ($urandom_range(0, 2) == 0 ? 8'($urandom_range(1, 7)) : 8'h00);
    if ($urandom_range(0, 19) == 0) flags = 8'($urandom);
    mtype = $urandom_range(0, 99) < 85 ? exp_type_reg : 8'($urandom);
    dlen = 16'(body.size() + (flags[2:0] != 0 ? 4 : 0));
    if ($urandom_range(0, 9) == 0)
      dlen = $urandom_range(0, 1) ? 16'($urandom) : 16'(dlen + $urandom_range(0, 6) - 3);
    teid = $urandom;
    pkt = {flags, mtype, dlen[15:8], dlen[7:0], teid[31:24], teid[23:16],
           teid[15:8], teid[7:0]};
    if (flags[2:0] != 0) repeat (4) pkt.insert(pkt.size(), 8'($urandom));
    foreach (body[i]) pkt.insert(pkt.size(), body[i]);
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, pkt.size());
      while (pkt.size() > cut) void'(pkt.pop_back());
    end
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 3)) pkt.insert(pkt.size(), 8'($urandom));
  endfunction

  // directed rows; status typed in on the final byte where obvious
  typedef struct {
    logic [7:0] b;
    logic       last;
    logic       ck;
    logic [3:0] st;
  } row_t;

  row_t directed[25] = '{
    // one byte only: too short, all fields zero
    '{8'hFF, 1'b1, 1'b1, ST_SHORT},
    // version 2 header
    '{8'h50, 1'b0, 1'b0, ST_OK}, '{8'h10, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b1, 1'b1, ST_VERSION},
    // good header, zero length: nothing to walk
    '{8'h30, 1'b0, 1'b0, ST_OK}, '{8'h10, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
    '{8'hDE, 1'b0, 1'b0, ST_OK}, '{8'hAD, 1'b0, 1'b0, ST_OK},
    '{8'hBE, 1'b0, 1'b0, ST_OK}, '{8'hEF, 1'b1, 1'b1, ST_NO_IES},
    // protocol type bit clear
    '{8'h20, 1'b0, 1'b0, ST_OK}, '{8'h10, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b1, 1'b1, ST_PROTO}
  };

  logic [7:0] cfg_vals[4];
  int sent;

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0; packet_byte_i = '0; end_of_packet_i = 1'b0;
    out_ready_i = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    chk_en = 1'b0; chk_status = ST_OK;
    errors = 0; quiet_cycles = 0; hold_req = 0; hold_done = 0; hold_left = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    exp_type_reg = EXP_TYPE_RESET;
    clear_packet();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i])
      send_byte(directed[i].b, directed[i].last, directed[i].ck, directed[i].st);
    wait_drained();

    // phases: no idling (with the long hold-off), sender idle, receiver
    // stalling, both; register swept through both extremes
    cfg_vals = '{8'h00, 8'hFF, 8'($urandom), EXP_TYPE_RESET};
    for (int ph = 0; ph < 4; ph++) begin
      apb_write(cfg_vals[ph]);
      send_idle_pct  = ph == 1 || ph == 3 ? (ph == 1 ? 88 : 33) : 0;
      recv_stall_pct = ph == 2 || ph == 3 ? (ph == 2 ? 88 : 33) : 0;
      if (ph == 0) hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_BYTES) begin
        build_packet();
        foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1, 1'b0, ST_OK);
        sent += pkt.size();
      end
      // sender pauses until every owed beat is back
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("gtpv1c_request_parser: match");
    else $display("gtpv1c_request_parser: mismatch");
    $finish;
  end

endmodule
